### src/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Shared constants, codes and types for the PCM sample FIFO to PWM duty block.
// ----------------------------------------------------------------------------
package psf_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    // PWM duty geometry
    localparam int DUTY_BITS = 8;
    localparam logic [DUTY_BITS-1:0] DUTY_MID =
        DUTY_BITS'(((64'd1 << DUTY_BITS) - 64'd1) / 64'd2);

    // Sample and gain widths
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 8;
    localparam int PROD_W   = SAMPLE_W + VOL_W + 1;

    // Divide by 100 as multiply by reciprocal; exact for magnitudes below 2^23
    localparam int DIVISOR   = 100;
    localparam int DIV_SHIFT = 30;
    localparam int MAG_W     = 24;
    localparam logic [MAG_W-1:0] DIV_MUL =
        MAG_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam int QMAG_W    = 2 * MAG_W - DIV_SHIFT;
    localparam int QUOT_W    = QMAG_W + 1;
    localparam int BIAS_W    = QUOT_W + 1;

    // Opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY   = 2'd2;
    localparam logic [VOL_W-1:0]     VOLUME_RESET = 8'd100;

    // Per-word status carried down the pipeline
    typedef struct packed {
        logic               is_tick;
        logic               played;
        logic               accepted;
        logic [LEVEL_W-1:0] level;
    } psf_tag_t;

endpackage

### src/psf_fifo.sv
// ----------------------------------------------------------------------------
// psf_fifo
// Input stage: stereo downmix, ring FIFO control and sample memory. Produces
// one registered word per accepted input with the popped sample and status.
// ----------------------------------------------------------------------------
module psf_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              stereo_mode,
    input  logic                              play_enable,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic signed [psf_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic signed [psf_pkg::SAMPLE_W-1:0] s_right_sample,
    output logic                              q_valid,
    input  logic                              q_ready,
    output logic signed [psf_pkg::SAMPLE_W-1:0] q_sample,
    output psf_pkg::psf_tag_t                 q_tag
);

    logic [psf_pkg::ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [psf_pkg::ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [psf_pkg::LEVEL_W-1:0] count_reg, count_next;
    logic                        valid_reg;
    psf_pkg::psf_tag_t           tag_reg, tag_next;
    logic [psf_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [psf_pkg::SAMPLE_W-1:0] mem [psf_pkg::FIFO_DEPTH];

    logic                         accept;
    logic                         do_push;
    logic                         do_pop;
    logic signed [psf_pkg::SAMPLE_W:0] pair_sum;
    logic signed [psf_pkg::SAMPLE_W:0] pair_avg;
    logic [psf_pkg::SAMPLE_W-1:0] push_sample;

    assign s_ready = !valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    // Stereo average, truncating toward zero
    assign pair_sum = {s_left_sample[psf_pkg::SAMPLE_W-1], s_left_sample}
                    + {s_right_sample[psf_pkg::SAMPLE_W-1], s_right_sample};
    assign pair_avg = (pair_sum + {{psf_pkg::SAMPLE_W{1'b0}},
                                   pair_sum[psf_pkg::SAMPLE_W]}) >>> 1;
    assign push_sample = stereo_mode ? pair_avg[psf_pkg::SAMPLE_W-1:0]
                                     : s_left_sample;

    assign do_push = accept && (s_opcode == psf_pkg::OP_PUSH)
                  && (count_reg < psf_pkg::LEVEL_W'(psf_pkg::FIFO_DEPTH));
    assign do_pop  = accept && (s_opcode == psf_pkg::OP_TICK)
                  && play_enable && (count_reg != '0);

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == psf_pkg::ADDR_W'(psf_pkg::FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == psf_pkg::ADDR_W'(psf_pkg::FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
        if (accept && (s_opcode == psf_pkg::OP_FLUSH)) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
    end

    // Status for the word
    always_comb begin
        tag_next.is_tick  = (s_opcode == psf_pkg::OP_TICK);
        tag_next.played   = do_pop;
        tag_next.accepted = do_push;
        tag_next.level    = count_next;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (s_ready) begin
                valid_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_reg <= tag_next;
        end
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign q_valid  = valid_reg;
    assign q_sample = rd_data_reg;
    assign q_tag    = tag_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= psf_pkg::LEVEL_W'(psf_pkg::FIFO_DEPTH))
        else $error("fifo count above depth");

    a_pop_push_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(tag_reg.played && tag_reg.accepted))
        else $error("word marked both pushed and played");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_opcode == psf_pkg::OP_FLUSH) |=> (count_reg == '0))
        else $error("flush left samples in fifo");

    a_played_is_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && tag_reg.played) |-> tag_reg.is_tick)
        else $error("sample played on a non-tick word");

endmodule

### src/psf_scale.sv
// ----------------------------------------------------------------------------
// psf_scale
// Volume scaling, divide by 100, offset, clamp and duty quantize, with the
// in-order duty hold and the output register.
// ----------------------------------------------------------------------------
module psf_scale (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [psf_pkg::VOL_W-1:0]           volume_percent,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic signed [psf_pkg::SAMPLE_W-1:0] q_sample,
    input  psf_pkg::psf_tag_t                   q_tag,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psf_pkg::DUTY_BITS-1:0]       m_pwm_duty,
    output logic                                m_sample_played,
    output logic                                m_push_accepted,
    output logic [psf_pkg::LEVEL_W-1:0]         m_fifo_level
);

    // Stage A: product
    logic                               a_valid_reg;
    psf_pkg::psf_tag_t                  a_tag_reg;
    logic signed [psf_pkg::PROD_W-1:0]  a_prod_reg;
    // Stage B: quotient
    logic                               b_valid_reg;
    psf_pkg::psf_tag_t                  b_tag_reg;
    logic signed [psf_pkg::QUOT_W-1:0]  b_quot_reg;
    // Output
    logic                               out_valid_reg;
    logic [psf_pkg::DUTY_BITS-1:0]      duty_hold_reg, duty_hold_next;
    logic                               played_reg;
    logic                               accepted_reg;
    logic [psf_pkg::LEVEL_W-1:0]        level_reg;

    logic                               out_ready;
    logic                               b_ready;
    logic                               a_ready;
    logic signed [psf_pkg::PROD_W-1:0]  prod;
    logic [psf_pkg::MAG_W-1:0]          prod_mag;
    logic [2*psf_pkg::MAG_W-1:0]        recip_prod;
    logic [psf_pkg::QMAG_W-1:0]         quot_mag;
    logic signed [psf_pkg::QUOT_W-1:0]  quot;
    logic signed [psf_pkg::BIAS_W-1:0]  biased;
    logic [psf_pkg::SAMPLE_W-1:0]       clamped;
    logic [psf_pkg::DUTY_BITS-1:0]      duty_calc;

    // Flow control, bubbles collapse
    assign out_ready = !out_valid_reg || m_ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign q_ready   = a_ready;

    // Sample times volume (volume is non-negative)
    assign prod = psf_pkg::PROD_W'(q_sample)
                * psf_pkg::PROD_W'($signed({1'b0, volume_percent}));

    // Magnitude times reciprocal of 100, then restore sign
    assign prod_mag   = a_prod_reg[psf_pkg::PROD_W-1]
                      ? psf_pkg::MAG_W'(-a_prod_reg)
                      : psf_pkg::MAG_W'(a_prod_reg);
    assign recip_prod = (2*psf_pkg::MAG_W)'(prod_mag)
                      * (2*psf_pkg::MAG_W)'(psf_pkg::DIV_MUL);
    assign quot_mag   = recip_prod[2*psf_pkg::MAG_W-1:psf_pkg::DIV_SHIFT];
    assign quot       = a_prod_reg[psf_pkg::PROD_W-1]
                      ? -$signed({1'b0, quot_mag})
                      : $signed({1'b0, quot_mag});

    // Offset to unsigned, clamp, keep the top duty bits
    assign biased = {b_quot_reg[psf_pkg::QUOT_W-1], b_quot_reg}
                  + psf_pkg::BIAS_W'(32768);
    always_comb begin
        priority if (biased < 0) begin
            clamped = '0;
        end else if (biased > psf_pkg::BIAS_W'(65535)) begin
            clamped = '1;
        end else begin
            clamped = biased[psf_pkg::SAMPLE_W-1:0];
        end
    end
    assign duty_calc = clamped[psf_pkg::SAMPLE_W-1 -: psf_pkg::DUTY_BITS];

    // Duty hold follows ticks in order
    always_comb begin
        duty_hold_next = duty_hold_reg;
        if (b_valid_reg && out_ready && b_tag_reg.is_tick) begin
            duty_hold_next = b_tag_reg.played ? duty_calc : psf_pkg::DUTY_MID;
        end
    end

    // Valid bits and duty hold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            duty_hold_reg <= psf_pkg::DUTY_MID;
        end else begin
            if (a_ready) begin
                a_valid_reg <= q_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= b_valid_reg;
            end
            duty_hold_reg <= duty_hold_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_valid && a_ready) begin
            a_tag_reg  <= q_tag;
            a_prod_reg <= prod;
        end
        if (a_valid_reg && b_ready) begin
            b_tag_reg  <= a_tag_reg;
            b_quot_reg <= quot;
        end
        if (b_valid_reg && out_ready) begin
            played_reg   <= b_tag_reg.played;
            accepted_reg <= b_tag_reg.accepted;
            level_reg    <= b_tag_reg.level;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pwm_duty      = duty_hold_reg;
    assign m_sample_played = played_reg;
    assign m_push_accepted = accepted_reg;
    assign m_fifo_level    = level_reg;

endmodule

### src/pcm_sample_fifo_to_pwm_duty.sv
// ----------------------------------------------------------------------------
// pcm_sample_fifo_to_pwm_duty
// PCM audio FIFO feeding an 8-bit PWM duty: push, tick and flush words in,
// one status word with the current duty out for each.
// ----------------------------------------------------------------------------
// One result word per input word, in order. A new word is taken every cycle
// while the result side is not stalling; the result word passes through the
// four register stages (FIFO read at the accepting edge, volume multiply,
// reciprocal divide by 100, clamp and quantize into the output register).
// The FIFO holds 1024 samples in a single-port-write, registered-read memory
// that needs no clearing after reset. Config writes (index 0 volume,
// 1 stereo, 2 play enable) are taken every cycle and should only be made
// while idle.
module pcm_sample_fifo_to_pwm_duty (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psf_pkg::VOL_W-1:0]           cfg_data,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic signed [psf_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic signed [psf_pkg::SAMPLE_W-1:0] s_right_sample,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psf_pkg::DUTY_BITS-1:0]       m_pwm_duty,
    output logic                                m_sample_played,
    output logic                                m_push_accepted,
    output logic [psf_pkg::LEVEL_W-1:0]         m_fifo_level
);

    logic [psf_pkg::VOL_W-1:0]           volume_reg;
    logic                                stereo_reg;
    logic                                play_reg;
    logic                                q_valid;
    logic                                q_ready;
    logic signed [psf_pkg::SAMPLE_W-1:0] q_sample;
    psf_pkg::psf_tag_t                   q_tag;

    // Config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= psf_pkg::VOLUME_RESET;
            stereo_reg <= 1'b0;
            play_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                psf_pkg::CFG_VOLUME: volume_reg <= cfg_data;
                psf_pkg::CFG_STEREO: stereo_reg <= cfg_data[0];
                psf_pkg::CFG_PLAY:   play_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // FIFO stage
    psf_fifo u_fifo (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .stereo_mode    (stereo_reg),
        .play_enable    (play_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_sample       (q_sample),
        .q_tag          (q_tag)
    );

    // Scaling and output stage
    psf_scale u_scale (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .volume_percent  (volume_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_sample        (q_sample),
        .q_tag           (q_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_duty      (m_pwm_duty),
        .m_sample_played (m_sample_played),
        .m_push_accepted (m_push_accepted),
        .m_fifo_level    (m_fifo_level)
    );

endmodule

### tb/tb_pcm_sample_fifo_to_pwm_duty.sv
// ----------------------------------------------------------------------------
// tb_pcm_sample_fifo_to_pwm_duty
// Self-checking bench for the PCM sample FIFO to PWM duty block. A scoreboard
// class keeps its own FIFO, pointers, duty hold and register copies, predicts
// the status word for every accepted push, tick, flush or ignored word, and
// compares the returned words in order. Directed corner words come first,
// then random traffic under several register settings, with random gaps on
// both channels.
// ----------------------------------------------------------------------------
module tb_pcm_sample_fifo_to_pwm_duty;
    timeunit 1ns;
    timeprecision 1ps;

    import psf_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PCT      = 8;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = 78;
    localparam int PCM_BIAS      = 32768;
    localparam int CODE_MAX      = 65535;

    // opcode the block ignores, and a config index with no register behind it
    localparam logic [1:0]           OP_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 played;
        logic                 accepted;
        logic [LEVEL_W-1:0]   level;
    } dac_status_t;

    // ------------------------------------------------------------------------
    // Scoreboard: FIFO/duty predictor plus in-order status check
    // ------------------------------------------------------------------------
    class duty_tracker;
        logic signed [SAMPLE_W-1:0] samples [FIFO_DEPTH];
        logic [ADDR_W-1:0]          wr_ptr;
        logic [ADDR_W-1:0]          rd_ptr;
        logic [LEVEL_W-1:0]         level;
        logic [DUTY_BITS-1:0]       duty_hold;
        logic [VOL_W-1:0]           volume;
        logic                       stereo;
        logic                       play;
        dac_status_t                due_status [$];
        int                         errors;

        function new();
            wr_ptr    = '0;
            rd_ptr    = '0;
            level     = '0;
            duty_hold = DUTY_MID;
            volume    = VOLUME_RESET;
            stereo    = 1'b0;
            play      = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VOL_W-1:0] data);
            case (idx)
                CFG_VOLUME: volume = data;
                CFG_STEREO: stereo = data[0];
                CFG_PLAY:   play   = data[0];
                default: ;
            endcase
        endfunction

        // gain in percent (truncating), re-bias to unsigned, clamp, quantize
        function logic [DUTY_BITS-1:0] scale_to_duty(logic signed [SAMPLE_W-1:0] pcm);
            int code;
            code = (int'(pcm) * int'(volume)) / DIVISOR + PCM_BIAS;
            if (code < 0) code = 0;
            if (code > CODE_MAX) code = CODE_MAX;
            return DUTY_BITS'(code >> (SAMPLE_W - DUTY_BITS));
        endfunction

        function void take_word(logic [1:0] op, logic signed [SAMPLE_W-1:0] left,
                                logic signed [SAMPLE_W-1:0] right);
            dac_status_t st;
            int          mix;
            st.played   = 1'b0;
            st.accepted = 1'b0;
            case (op)
                OP_PUSH: begin
                    mix = stereo ? (int'(left) + int'(right)) / 2 : int'(left);
                    // full FIFO drops the frame
                    if (level < FIFO_DEPTH) begin
                        samples[wr_ptr] = SAMPLE_W'(mix);
                        wr_ptr++;
                        level++;
                        st.accepted = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (play && level != 0) begin
                        duty_hold = scale_to_duty(samples[rd_ptr]);
                        rd_ptr++;
                        level--;
                        st.played = 1'b1;
                    end else begin
                        duty_hold = DUTY_MID;
                    end
                end
                OP_FLUSH: begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                    level  = '0;
                end
                default: ;
            endcase
            st.duty  = duty_hold;
            st.level = level;
            due_status.push_back(st);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [DUTY_BITS-1:0] duty, logic played,
                                   logic accepted, logic [LEVEL_W-1:0] lvl);
            dac_status_t want;
            if (due_status.size() == 0) begin
                $display("%0t: unexpected status word, expected none actual duty %0d level %0d",
                         $time, duty, lvl);
                errors++;
                return;
            end
            want = due_status.pop_front();
            compare_field("pwm_duty", want.duty, duty);
            compare_field("sample_played", want.played, played);
            compare_field("push_accepted", want.accepted, accepted);
            compare_field("fifo_level", want.level, lvl);
        endfunction

        function int pending();
            return due_status.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [VOL_W-1:0]           cfg_data       = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_opcode       = OP_PUSH;
    logic signed [SAMPLE_W-1:0] s_left_sample  = '0;
    logic signed [SAMPLE_W-1:0] s_right_sample = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic [DUTY_BITS-1:0]       m_pwm_duty;
    logic                       m_sample_played;
    logic                       m_push_accepted;
    logic [LEVEL_W-1:0]         m_fifo_level;

    duty_tracker tracker     = new();
    bit          gaps_on     = 1'b1;
    int          cycle_count = 0;

    pcm_sample_fifo_to_pwm_duty u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_left_sample   (s_left_sample),
        .s_right_sample  (s_right_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_duty      (m_pwm_duty),
        .m_sample_played (m_sample_played),
        .m_push_accepted (m_push_accepted),
        .m_fifo_level    (m_fifo_level)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pcm_sample_fifo_to_pwm_duty verification failed");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_status(m_pwm_duty, m_sample_played, m_push_accepted, m_fifo_level);
        m_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    task automatic send_word(logic [1:0] op, logic signed [SAMPLE_W-1:0] left,
                             logic signed [SAMPLE_W-1:0] right);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_left_sample  <= left;
        s_right_sample <= right;
        do @(posedge aclk); while (!s_ready);
        tracker.take_word(op, left, right);
    endtask

    // wait for every outstanding status word, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [VOL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 48) return OP_PUSH;
        if (pick < 90) return OP_TICK;
        if (pick < 95) return OP_FLUSH;
        return OP_IGNORED;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [VOL_W-1:0] phase_volume [RAND_PHASES];
        phase_volume = '{8'd100, 8'd0, 8'd255, 8'd1, 8'd99, 8'd101, 8'd50, 8'd200};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: mono, unity gain, playback off
        cfg_write(CFG_UNUSED, 8'h5A);
        send_word(OP_TICK, '0, '0);
        send_word(OP_IGNORED, 16'sh7FFF, 16'sh8000);
        send_word(OP_PUSH, 16'sh7FFF, 16'sh8000);
        send_word(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_word(OP_PUSH, '0, '0);
        send_word(OP_TICK, '0, '0);        // disabled with data waiting
        send_word(OP_FLUSH, '0, '0);
        wait_idle();

        // stereo averaging at full gain, clamping both ways
        cfg_write(CFG_PLAY, 8'hFF);
        cfg_write(CFG_STEREO, 8'h01);
        cfg_write(CFG_VOLUME, 8'hFF);
        send_word(OP_PUSH, 16'sh7FFF, 16'sh7FFF);
        send_word(OP_PUSH, 16'sh8000, 16'sh8000);
        send_word(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_word(OP_PUSH, -16'sd3, 16'sd0);
        send_word(OP_PUSH, 16'sd3, 16'sd0);
        send_word(OP_PUSH, 16'sh7FFF, 16'sh8000);
        repeat (7) send_word(OP_TICK, '0, '0); // last one underruns
        wait_idle();

        // zero gain, upper data bits on a 1-bit register
        cfg_write(CFG_VOLUME, 8'h00);
        cfg_write(CFG_STEREO, 8'hFE);
        send_word(OP_PUSH, 16'sh8000, 16'sh7FFF);
        send_word(OP_TICK, '0, '0);
        send_word(OP_IGNORED, 16'sh8000, 16'sh8000);
        send_word(OP_PUSH, 16'sd1, -16'sd1);
        send_word(OP_FLUSH, '0, '0);        // duty held across flush
        send_word(OP_TICK, '0, '0);
        wait_idle();

        // random traffic under several settings; two phases run without gaps
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p >= 6) phase_volume[p] = VOL_W'($urandom);
            cfg_write(CFG_VOLUME, phase_volume[p]);
            cfg_write(CFG_STEREO, VOL_W'(p & 1));
            cfg_write(CFG_PLAY, (p == 2) ? 8'h00 : 8'h01);
            gaps_on = !(p == 4 || p == 5);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(rand_op(), rand_sample(), rand_sample());
            wait_idle();
        end

        if (tracker.errors == 0) begin
            $display("pcm_sample_fifo_to_pwm_duty verification clean");
        end else begin
            $display("pcm_sample_fifo_to_pwm_duty verification failed");
        end
        $finish;
    end

endmodule

### pcm_sample_fifo_to_pwm_duty.f
src/psf_pkg.sv
src/psf_fifo.sv
src/psf_scale.sv
src/pcm_sample_fifo_to_pwm_duty.sv
tb/tb_pcm_sample_fifo_to_pwm_duty.sv
